// ----- hw/rtl/gsac_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsac_pkg
// Shared types, constants and the speed band lookup for the gauge stepper
// acceleration controller.
// ----------------------------------------------------------------------------
package gsac_pkg;

    localparam int unsigned DEGREE_SPAN = 315;
    localparam int unsigned POS_W       = 12;
    localparam int unsigned SPEED_W     = 9;
    localparam int unsigned DELAY_W     = 16;
    localparam int unsigned NUM_BANDS   = 5;
    localparam int unsigned BAND_W      = 3;

    localparam logic [POS_W-1:0]   TOP_POS   = POS_W'(DEGREE_SPAN * 3 * 4);
    localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(300);

    localparam logic [SPEED_W-1:0] BAND_LIMIT_0 = SPEED_W'(20);
    localparam logic [SPEED_W-1:0] BAND_LIMIT_1 = SPEED_W'(50);
    localparam logic [SPEED_W-1:0] BAND_LIMIT_2 = SPEED_W'(100);
    localparam logic [SPEED_W-1:0] BAND_LIMIT_3 = SPEED_W'(150);

    localparam logic [DELAY_W-1:0] DELAY_RST_20  = DELAY_W'(800);
    localparam logic [DELAY_W-1:0] DELAY_RST_50  = DELAY_W'(400);
    localparam logic [DELAY_W-1:0] DELAY_RST_100 = DELAY_W'(200);
    localparam logic [DELAY_W-1:0] DELAY_RST_150 = DELAY_W'(150);
    localparam logic [DELAY_W-1:0] DELAY_RST_300 = DELAY_W'(90);

    typedef enum logic [BAND_W-1:0] {
        CFG_DELAY_UPTO_20  = 3'd0,
        CFG_DELAY_UPTO_50  = 3'd1,
        CFG_DELAY_UPTO_100 = 3'd2,
        CFG_DELAY_UPTO_150 = 3'd3,
        CFG_DELAY_UPTO_300 = 3'd4
    } t_band;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_TARGET = 2'd1,
        FUNC_HOME   = 2'd2,
        FUNC_UNUSED = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        HEAD_NONE = 2'd0,
        HEAD_UP   = 2'd1,
        HEAD_DOWN = 2'd2
    } t_heading;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_STARTED  = 3'd1,
        EV_HOMING   = 3'd2,
        EV_READY    = 3'd3,
        EV_FINISHED = 3'd4
    } t_event;

    function automatic t_band band_of(input logic [SPEED_W-1:0] speed);
        t_band band;
        if (speed <= BAND_LIMIT_0) begin
            band = CFG_DELAY_UPTO_20;
        end else if (speed <= BAND_LIMIT_1) begin
            band = CFG_DELAY_UPTO_50;
        end else if (speed <= BAND_LIMIT_2) begin
            band = CFG_DELAY_UPTO_100;
        end else if (speed <= BAND_LIMIT_3) begin
            band = CFG_DELAY_UPTO_150;
        end else begin
            band = CFG_DELAY_UPTO_300;
        end
        return band;
    endfunction

endpackage

// ----- hw/rtl/gauge_stepper_accel_controller_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gauge_stepper_accel_controller_core
// Gauge stepper motion controller with a trapezoidal speed profile.
//
// Requests enter on the slave stream: tuser carries the event kind (tick,
// set target, home), tdata carries the target position. Each request gives
// exactly one result on the master stream: step pulse, direction, position,
// rearm flag and tick delay in tdata, event code in tuser.
// A request is captured in an input register, processed against the motion
// state once the result register is free, and lands in the result register,
// where it is shown until taken. One request per cycle is accepted while the
// result register drains; the combinational compare, step and speed update
// set that rate.
// When the receiver stalls, the result register holds and the input
// register takes one more request before o_s_tready drops.
// The configuration channel writes the five tick delay bands (index 0..4);
// writes are always taken, unknown indexes are dropped.
// Reset clears position, target, speed, heading and homing, loads the
// default delay bands and empties both registers.
// ----------------------------------------------------------------------------
module gauge_stepper_accel_controller_core
    import gsac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [11:0] target_position, [15:12] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [0] step_pulse, [1] step_dir,
                                     // [13:2] position, [14] rearm,
                                     // [30:15] tick_delay, [31] zero
    output logic [2:0]  o_m_tuser,   // [2:0] event_code
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic                r_in_valid;
    t_func               r_func;
    logic [POS_W-1:0]    r_req;

    logic                r_out_valid;
    logic                r_pulse;
    logic                r_dir;
    logic [POS_W-1:0]    r_pos_out;
    logic                r_rearm;
    logic [DELAY_W-1:0]  r_delay;
    t_event              r_event;

    logic [POS_W-1:0]    r_cur;
    logic [POS_W-1:0]    r_tgt;
    logic [SPEED_W-1:0]  r_speed;
    t_heading            r_heading;
    logic                r_homing;
    logic [DELAY_W-1:0]  r_band [NUM_BANDS];

    logic                out_free;
    logic                advance;

    logic [POS_W-1:0]    n_cur;
    logic [POS_W-1:0]    n_tgt;
    logic [SPEED_W-1:0]  n_speed;
    t_heading            n_heading;
    logic                n_homing;
    logic                n_pulse;
    logic                n_rearm;
    logic [DELAY_W-1:0]  n_delay;
    t_event              n_event;

    logic [SPEED_W-1:0]  sp1;
    t_heading            hd;
    logic [POS_W:0]      delta;
    logic [POS_W-1:0]    req_clamped;

    assign out_free    = !r_out_valid || i_m_tready;
    assign advance     = r_in_valid && out_free;
    assign o_s_tready  = !r_in_valid || out_free;
    assign o_cfg_ready = 1'b1;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_delay, r_rearm, r_pos_out, r_dir, r_pulse};
    assign o_m_tuser  = r_event;

    assign req_clamped = (r_req >= TOP_POS) ? TOP_POS - POS_W'(1) : r_req;

    always_comb begin
        n_cur     = r_cur;
        n_tgt     = r_tgt;
        n_speed   = r_speed;
        n_heading = r_heading;
        n_homing  = r_homing;
        n_pulse   = 1'b0;
        n_rearm   = 1'b0;
        n_event   = EV_NONE;
        sp1       = (r_speed == '0) ? SPEED_W'(1) : r_speed;
        hd        = r_heading;
        delta     = '0;
        case (r_func)
            FUNC_TICK: begin
                if (r_cur == r_tgt && r_speed == '0) begin
                    n_event   = r_homing ? EV_READY : EV_FINISHED;
                    n_homing  = 1'b0;
                    n_heading = HEAD_NONE;
                end else begin
                    if (r_speed == '0) begin
                        hd = (r_cur < r_tgt) ? HEAD_UP : HEAD_DOWN;
                    end
                    n_heading = hd;
                    if (hd == HEAD_UP) begin
                        if (r_cur < TOP_POS) begin
                            n_cur   = r_cur + POS_W'(1);
                            n_pulse = 1'b1;
                        end
                        delta = {1'b0, r_tgt} - {1'b0, n_cur};
                    end else begin
                        if (r_cur != '0) begin
                            n_cur   = r_cur - POS_W'(1);
                            n_pulse = 1'b1;
                        end
                        delta = {1'b0, n_cur} - {1'b0, r_tgt};
                    end
                    if (!delta[POS_W] && delta != '0) begin
                        if (delta < (POS_W+1)'(sp1)) begin
                            n_speed = sp1 - SPEED_W'(1);
                        end else if (sp1 < SPEED_MAX) begin
                            n_speed = sp1 + SPEED_W'(1);
                        end else begin
                            n_speed = sp1;
                        end
                    end else begin
                        n_speed = sp1 - SPEED_W'(1);
                    end
                    n_rearm = 1'b1;
                end
            end
            FUNC_TARGET: begin
                if (!r_homing) begin
                    n_tgt   = req_clamped;
                    n_event = EV_STARTED;
                    n_rearm = 1'b1;
                end
            end
            FUNC_HOME: begin
                n_cur     = TOP_POS - POS_W'(1);
                n_tgt     = '0;
                n_speed   = '0;
                n_heading = HEAD_DOWN;
                n_homing  = 1'b1;
                n_event   = EV_HOMING;
                n_rearm   = 1'b1;
            end
            default: begin
            end
        endcase
        n_delay = n_rearm ? r_band[band_of(n_speed)] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_func <= t_func'(i_s_tuser);
            r_req  <= i_s_tdata[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_pulse   <= n_pulse;
            r_dir     <= (n_heading == HEAD_UP);
            r_pos_out <= n_cur;
            r_rearm   <= n_rearm;
            r_delay   <= n_delay;
            r_event   <= n_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur     <= '0;
            r_tgt     <= '0;
            r_speed   <= '0;
            r_heading <= HEAD_NONE;
            r_homing  <= 1'b0;
        end else if (advance) begin
            r_cur     <= n_cur;
            r_tgt     <= n_tgt;
            r_speed   <= n_speed;
            r_heading <= n_heading;
            r_homing  <= n_homing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band[CFG_DELAY_UPTO_20]  <= DELAY_RST_20;
            r_band[CFG_DELAY_UPTO_50]  <= DELAY_RST_50;
            r_band[CFG_DELAY_UPTO_100] <= DELAY_RST_100;
            r_band[CFG_DELAY_UPTO_150] <= DELAY_RST_150;
            r_band[CFG_DELAY_UPTO_300] <= DELAY_RST_300;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DELAY_UPTO_20:  r_band[CFG_DELAY_UPTO_20]  <= i_cfg_data;
                CFG_DELAY_UPTO_50:  r_band[CFG_DELAY_UPTO_50]  <= i_cfg_data;
                CFG_DELAY_UPTO_100: r_band[CFG_DELAY_UPTO_100] <= i_cfg_data;
                CFG_DELAY_UPTO_150: r_band[CFG_DELAY_UPTO_150] <= i_cfg_data;
                CFG_DELAY_UPTO_300: r_band[CFG_DELAY_UPTO_300] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= TOP_POS)
        else $error("position beyond top");

    a_speed_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_speed <= SPEED_MAX)
        else $error("speed beyond maximum");

    a_homing_target_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_homing |-> (r_tgt == '0))
        else $error("target moved while homing");

    a_delay_only_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_rearm) |-> (r_delay == '0))
        else $error("tick delay without rearm");

    a_pulse_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_pulse) |-> (r_event == EV_NONE && r_rearm))
        else $error("step pulse with event code");

endmodule
